// ===== rtl/cwr_pkg.sv =====
// Shared types, constants and helpers for the cell wall ray hit test.
package cwr_pkg;

  // Angle and geometry
  localparam int unsigned AngleBits = 16;
  localparam int unsigned HeadingW  = 16;
  localparam int unsigned HalfSize  = 1344;
  localparam int unsigned DeadBand  = 3;

  // Field widths
  localparam int unsigned PosW   = 24;
  localparam int unsigned LocW   = PosW + 1;   // pose minus origin
  localparam int unsigned OffW   = PosW + 2;   // half size plus/minus local
  localparam int unsigned TrigW  = 17;         // Q1.15 after quadrant negate
  localparam int unsigned HalfW  = 17;
  localparam int unsigned ProdW  = OffW + TrigW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned BndW   = HalfW + TrigW + 1;
  localparam int unsigned MaskW  = 4;
  localparam int unsigned CfgIdxW = 2;

  // CORDIC
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned StepW = $clog2(CordicSteps);
  localparam int unsigned CxW   = 34;
  localparam int unsigned PhW   = 32;
  localparam logic signed [CxW-1:0] CORDIC_X0 = CxW'(652032874);

  localparam logic signed [PhW-1:0] ATAN_TAB [CordicSteps] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
    32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
    32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304
  };

  localparam logic signed [OffW-1:0] HALF_OFF = OffW'(HalfSize);
  localparam logic signed [HalfW-1:0] HALF_H  = HalfW'(HalfSize);
  localparam logic signed [TrigW-1:0] DEAD_P  = TrigW'(DeadBand);
  localparam logic signed [TrigW-1:0] DEAD_N  = -TrigW'(DeadBand);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WALL_MASK = 2'd0,
    CFG_ORIGIN_X  = 2'd1,
    CFG_ORIGIN_Y  = 2'd2
  } cfg_reg_t;

  // Data carried along the CORDIC chain
  typedef struct packed {
    logic signed [CxW-1:0]  x;
    logic signed [CxW-1:0]  y;
    logic signed [PhW-1:0]  z;
    logic [1:0]             quad;
    logic signed [LocW-1:0] lx;
    logic signed [LocW-1:0] ly;
  } cordic_t;

  function automatic logic signed [ProdW-1:0] smul(input logic signed [OffW-1:0] a,
                                                   input logic signed [TrigW-1:0] b);
    smul = ProdW'(a) * ProdW'(b);
  endfunction

endpackage

// ===== rtl/cwr_cordic_cell.sv =====
// One rotation step of the CORDIC chain, registered.
module cwr_cordic_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [cwr_pkg::StepW-1:0]      step,
  input  logic                           in_vld,
  input  cwr_pkg::cordic_t               din,
  output logic                           out_vld,
  output cwr_pkg::cordic_t               dout
);
  import cwr_pkg::*;

  logic signed [CxW-1:0] dx;
  logic signed [CxW-1:0] dy;
  logic signed [PhW-1:0] ang;

  assign dx  = din.y >>> step;
  assign dy  = din.x >>> step;
  assign ang = ATAN_TAB[step];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.quad <= din.quad;
      dout.lx   <= din.lx;
      dout.ly   <= din.ly;
      if (!din.z[PhW-1]) begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - ang;
      end else begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + ang;
      end
    end
  end

endmodule

// ===== rtl/cwr_wall_test.sv =====
// Rounding, quadrant fold and the four cross-multiplied wall tests.
module cwr_wall_test (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [cwr_pkg::MaskW-1:0]   wall_mask,
  input  logic                        in_vld,
  input  cwr_pkg::cordic_t            din,
  output logic                        hit_vld,
  output logic                        hit
);
  import cwr_pkg::*;

  function automatic logic signed [TrigW-1:0] to_q15(input logic signed [CxW-1:0] v);
    logic signed [CxW-1:0] t;
    t = (v + CxW'(16384)) >>> 15;
    if (t > CxW'(32767))
      to_q15 = TrigW'(32767);
    else if (t < -CxW'(32768))
      to_q15 = -TrigW'(32768);
    else
      to_q15 = TrigW'(t);
  endfunction

  // round / quadrant stage
  logic                    r_vld;
  logic signed [TrigW-1:0] cq, sq, r_c, r_s;
  logic signed [LocW-1:0]  r_lx, r_ly;

  // product stage
  logic                    p_vld;
  logic signed [ProdW-1:0] p_lxs, p_lyc, p_hmly_c, p_hplx_s, p_hmlx_s, p_hply_c;
  logic signed [BndW-1:0]  p_bs, p_bc;
  logic [MaskW-1:0]        p_dir;

  // sum stage
  logic                    s_vld;
  logic signed [SumW-1:0]  sum_n, sum_w, sum_e, sum_s;
  logic signed [SumW-1:0]  s_an, s_aw, s_ae, s_as;
  logic signed [BndW-1:0]  s_bs, s_bc;
  logic [MaskW-1:0]        s_dir;

  logic [MaskW-1:0]        wall_hit;
  logic signed [OffW-1:0]  lx_e, ly_e;

  assign cq = to_q15(din.x);
  assign sq = to_q15(din.y);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld   <= 1'b0;
      p_vld   <= 1'b0;
      s_vld   <= 1'b0;
      hit_vld <= 1'b0;
    end else if (en) begin
      r_vld   <= in_vld;
      p_vld   <= r_vld;
      s_vld   <= p_vld;
      hit_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_lx <= din.lx;
      r_ly <= din.ly;
      case (din.quad)
        2'd0: begin r_c <= cq;  r_s <= sq;  end
        2'd1: begin r_c <= -sq; r_s <= cq;  end
        2'd2: begin r_c <= -cq; r_s <= -sq; end
        default: begin r_c <= sq; r_s <= -cq; end
      endcase
    end
  end

  assign lx_e = OffW'(r_lx);
  assign ly_e = OffW'(r_ly);

  always_ff @(posedge clk) begin
    if (en) begin
      p_lxs    <= smul(lx_e, r_s);
      p_lyc    <= smul(ly_e, r_c);
      p_hmly_c <= smul(HALF_OFF - ly_e, r_c);
      p_hplx_s <= smul(HALF_OFF + lx_e, r_s);
      p_hmlx_s <= smul(HALF_OFF - lx_e, r_s);
      p_hply_c <= smul(HALF_OFF + ly_e, r_c);
      p_bs     <= BndW'(HALF_H) * BndW'(r_s);
      p_bc     <= BndW'(HALF_H) * BndW'(r_c);
      // crossing directions, bit 0 to bit 3: north, west, east, south
      p_dir    <= {r_s < DEAD_N, r_c > DEAD_P, r_c < DEAD_N, r_s > DEAD_P};
    end
  end

  assign sum_n = SumW'(p_lxs) + SumW'(p_hmly_c);
  assign sum_w = SumW'(p_lyc) - SumW'(p_hplx_s);
  assign sum_e = SumW'(p_lyc) + SumW'(p_hmlx_s);
  assign sum_s = SumW'(p_lxs) - SumW'(p_hply_c);

  always_ff @(posedge clk) begin
    if (en) begin
      s_an  <= sum_n[SumW-1] ? -sum_n : sum_n;
      s_aw  <= sum_w[SumW-1] ? -sum_w : sum_w;
      s_ae  <= sum_e[SumW-1] ? -sum_e : sum_e;
      s_as  <= sum_s[SumW-1] ? -sum_s : sum_s;
      s_bs  <= p_bs;
      s_bc  <= p_bc;
      s_dir <= p_dir;
    end
  end

  assign wall_hit[0] = s_dir[0] && (s_an <= SumW'(s_bs));
  assign wall_hit[1] = s_dir[1] && (s_aw <= -SumW'(s_bc));
  assign wall_hit[2] = s_dir[2] && (s_ae <= SumW'(s_bc));
  assign wall_hit[3] = s_dir[3] && (s_as <= -SumW'(s_bs));

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= |(wall_hit & wall_mask);
    end
  end

endmodule

// ===== rtl/cell_wall_ray_hit_test.sv =====
// Top level: config registers, entry stage, CORDIC cell chain and wall tests.
// The path from input transaction to result runs through the entry stage, 20
// CORDIC cells, round, multiply, sum and the compare/output register.
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds only while a finished result is stalled at the output register.
// Reset (rst, synchronous): clears all valid bits and the config registers.
module cell_wall_ray_hit_test (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cwr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cwr_pkg::PosW-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [cwr_pkg::PosW-1:0] pose_x,
  input  logic signed [cwr_pkg::PosW-1:0] pose_y,
  input  logic [cwr_pkg::HeadingW-1:0]  heading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          faces_wall
);
  import cwr_pkg::*;

  logic [MaskW-1:0]       wall_mask;
  logic signed [PosW-1:0] origin_x, origin_y;

  logic                   en;
  logic [PhW-1:0]         phase;
  logic [1:0]             quad;
  logic [PhW-1:0]         resid;

  logic                   e_vld;
  cordic_t                e_data;
  logic                   vld_chain [CordicSteps+1];
  cordic_t                data_chain [CordicSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_mask <= '0;
      origin_x  <= '0;
      origin_y  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WALL_MASK: wall_mask <= cfg_data[MaskW-1:0];
        CFG_ORIGIN_X:  origin_x  <= cfg_data;
        CFG_ORIGIN_Y:  origin_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // heading to 32-bit phase; fold to a quadrant and a residual in [-1/8, 1/8) turn
  assign phase = PhW'(heading) << (PhW - AngleBits);
  assign quad  = 2'((phase + 32'h2000_0000) >> 30);
  assign resid = phase - {quad, 30'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_data.x    <= CORDIC_X0;
      e_data.y    <= '0;
      e_data.z    <= $signed(resid);
      e_data.quad <= quad;
      e_data.lx   <= LocW'(pose_x) - LocW'(origin_x);
      e_data.ly   <= LocW'(pose_y) - LocW'(origin_y);
    end
  end

  assign vld_chain[0]  = e_vld;
  assign data_chain[0] = e_data;

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
    cwr_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .step    (StepW'(i)),
      .in_vld  (vld_chain[i]),
      .din     (data_chain[i]),
      .out_vld (vld_chain[i+1]),
      .dout    (data_chain[i+1])
    );
  end

  cwr_wall_test u_wall (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .wall_mask (wall_mask),
    .in_vld    (vld_chain[CordicSteps]),
    .din       (data_chain[CordicSteps]),
    .hit_vld   (out_valid),
    .hit       (faces_wall)
  );

  // stall reaches the input only from a held result
  a_stall_src: assert property (@(posedge clk) in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // an accepted transaction enters the entry stage
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> e_vld)
    else $error("accepted transaction lost at entry");

  // chain holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> ($stable(e_vld) && vld_chain[CordicSteps] == $past(vld_chain[CordicSteps])))
    else $error("pipeline moved during stall");

  a_reset: assert property (@(posedge clk) $past(rst) |-> (!out_valid && !e_vld))
    else $error("valid set right after reset");

endmodule

// ===== test/cell_wall_ray_hit_test_tb.sv =====
// Self-checking testbench for the cell wall ray hit test, with its own predictor.
module cell_wall_ray_hit_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cwr_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 6;
  localparam int LATENCY      = 25;
  localparam int RAND_PHASES  = 11;
  localparam int PHASE_POSES  = 50;
  localparam int MAX_PRINTS   = 30;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;   // no register behind it
  localparam logic signed [PosW-1:0] PMAX = 24'sh7FFFFF;
  localparam logic signed [PosW-1:0] PMIN = 24'sh800000;
  localparam longint GAIN_X0 = 652032874;
  localparam longint ATAN_STEP [20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  typedef struct packed {
    logic [MaskW-1:0]       mask;
    logic signed [PosW-1:0] ox;
    logic signed [PosW-1:0] oy;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic [HeadingW-1:0]    hd;
    logic                   typed;
    logic                   hit;
  } pose_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [PosW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PosW-1:0] pose_x = '0;
  logic signed [PosW-1:0] pose_y = '0;
  logic [HeadingW-1:0] heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic faces_wall;

  // predictor's copy of the cell registers
  logic [MaskW-1:0] cell_mask = '0;
  logic signed [PosW-1:0] cell_ox = '0;
  logic signed [PosW-1:0] cell_oy = '0;

  bit hit_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int stall_left = 0;
  bit stall_on = 1'b0;

  pose_row_t dir_rows [24] = '{
    '{4'h0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 1'b1, 1'b0},
    '{4'h0, 24'sd0, 24'sd0, PMAX, PMIN, 16'hFFFF, 1'b1, 1'b0},
    '{4'h0, 24'sd0, 24'sd0, PMIN, PMAX, 16'h8000, 1'b1, 1'b0},
    '{4'hF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 1'b1, 1'b1},
    '{4'hF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h4000, 1'b1, 1'b1},
    '{4'hF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h8000, 1'b1, 1'b1},
    '{4'hF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'hC000, 1'b1, 1'b1},
    '{4'hF, 24'sd0, 24'sd0, 24'sd0, 24'sd3000, 16'h4000, 1'b0, 1'b0},
    '{4'hF, 24'sd0, 24'sd0, 24'sd3000, 24'sd0, 16'h4000, 1'b0, 1'b0},
    '{4'hF, 24'sd0, 24'sd0, 24'sd0, 24'sd1344, 16'h0000, 1'b0, 1'b0},
    '{4'hF, 24'sd0, 24'sd0, 24'sd1344, 24'sd1344, 16'h2000, 1'b0, 1'b0},
    '{4'hF, 24'sd0, 24'sd0, 24'sd2688, 24'sd0, 16'h2000, 1'b0, 1'b0},
    '{4'h1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0001, 1'b0, 1'b0},
    '{4'h1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0002, 1'b0, 1'b0},
    '{4'h1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'hFFFF, 1'b0, 1'b0},
    '{4'h1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h7FFF, 1'b0, 1'b0},
    '{4'h2, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h8001, 1'b0, 1'b0},
    '{4'h4, 24'sd0, 24'sd0, 24'sd100, -24'sd200, 16'h1234, 1'b0, 1'b0},
    '{4'h8, 24'sd0, 24'sd0, -24'sd500, 24'sd700, 16'hD000, 1'b0, 1'b0},
    '{4'hF, PMAX, PMIN, PMIN, PMAX, 16'h6000, 1'b0, 1'b0},
    '{4'hF, PMIN, PMAX, PMAX, PMIN, 16'hE000, 1'b0, 1'b0},
    '{4'hF, PMIN, PMAX, PMIN + 24'sd100, PMAX - 24'sd100, 16'h4000, 1'b0, 1'b0},
    '{4'hF, PMAX, PMIN, PMAX, PMIN, 16'hA5A5, 1'b0, 1'b0},
    '{4'hF, 24'sd1000, -24'sd2000, 24'sd2344, -24'sd2000, 16'h4000, 1'b0, 1'b0}
  };

  cell_wall_ray_hit_test u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pose_x     (pose_x),
    .pose_y     (pose_y),
    .heading    (heading),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .faces_wall (faces_wall)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint to_trig(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit predict_hit(input logic signed [PosW-1:0] px,
                                     input logic signed [PosW-1:0] py,
                                     input logic [HeadingW-1:0] hd);
    longint lx, ly, x, y, z, dx, dy, c, s, h, db;
    logic [31:0] phase, resid;
    logic [1:0] quad;
    bit hit;
    h  = HalfSize;
    db = DeadBand;
    lx = longint'(px) - longint'(cell_ox);
    ly = longint'(py) - longint'(cell_oy);
    phase = 32'(hd) << (32 - AngleBits);
    quad  = 2'((phase + 32'h2000_0000) >> 30);
    resid = phase - {quad, 30'd0};
    z = longint'(signed'(resid));
    x = GAIN_X0;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end else begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end
    end
    c = to_trig(x);
    s = to_trig(y);
    case (quad)
      2'd0: begin x = c;  y = s;  end
      2'd1: begin x = -s; y = c;  end
      2'd2: begin x = -c; y = -s; end
      default: begin x = s; y = -c; end
    endcase
    c = x;
    s = y;
    hit = 1'b0;
    // north, west, east, south; a near-parallel wall never counts
    if (cell_mask[0] && s > db && mag(lx * s + (h - ly) * c) <= h * s) hit = 1'b1;
    if (!hit && cell_mask[1] && c < -db && mag(ly * c - (h + lx) * s) <= -h * c) hit = 1'b1;
    if (!hit && cell_mask[2] && c > db && mag(ly * c + (h - lx) * s) <= h * c) hit = 1'b1;
    if (!hit && cell_mask[3] && s < -db && mag(lx * s - (h + ly) * c) <= -h * s) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic signed [PosW-1:0] near(input logic signed [PosW-1:0] base);
    longint v;
    v = longint'(base) + longint'($urandom_range(0, 6000)) - 3000;
    if (v > longint'(PMAX)) v = longint'(PMAX);
    if (v < longint'(PMIN)) v = longint'(PMIN);
    return PosW'(v);
  endfunction

  function automatic logic signed [PosW-1:0] pick_origin();
    case ($urandom_range(0, 7))
      0: return PMAX;
      1: return PMIN;
      2: return 24'sd0;
      3: return PosW'($urandom);
      default: return PosW'(int'($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // registers change only with the pipeline empty
  task automatic load_cell(input logic [MaskW-1:0] mask, input logic signed [PosW-1:0] ox,
                           input logic signed [PosW-1:0] oy);
    write_reg(CFG_WALL_MASK, {20'($urandom), mask});
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_SPARE, PosW'($urandom));
    cfg_we <= 1'b0;
    cell_mask = mask;
    cell_ox = ox;
    cell_oy = oy;
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic idle_sender();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_pose(input logic signed [PosW-1:0] px, input logic signed [PosW-1:0] py,
                           input logic [HeadingW-1:0] hd, input bit typed, input bit hit);
    in_valid <= 1'b1;
    pose_x <= px;
    pose_y <= py;
    heading <= hd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit_q.insert(hit_q.size(), typed ? hit : predict_hit(px, py, hd));
  endtask

  // receiver stall: stretches of none, short bursts, now and then a long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left == 0) begin
      int r;
      r = $urandom_range(0, 99);
      stall_on = (r >= 60);
      stall_left = (r < 60) ? $urandom_range(1, 30) :
                   (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      out_stall <= stall_on;
    end else begin
      stall_left--;
      out_stall <= stall_on ? 1'b1 : 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    bit want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (hit_q.size() == 0) begin
        report_mismatch($sformatf("result %0d: faces_wall=%b with none expected",
                                  results_seen, faces_wall));
      end else begin
        want = hit_q.pop_front();
        if (faces_wall !== want)
          report_mismatch($sformatf("result %0d: faces_wall=%b, expected %b",
                                    results_seen, faces_wall, want));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    pose_row_t row;
    logic signed [PosW-1:0] px, py;
    logic [HeadingW-1:0] hd;
    logic [MaskW-1:0] mask;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.mask != cell_mask || row.ox != cell_ox || row.oy != cell_oy) begin
        settle_pipeline();
        load_cell(row.mask, row.ox, row.oy);
      end
      idle_sender();
      send_pose(row.px, row.py, row.hd, row.typed, row.hit);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_pipeline();
      mask = MaskW'($urandom);
      case (ph)
        0: load_cell(4'hF, pick_origin(), pick_origin());
        1: load_cell(4'hF, PMAX, PMIN);
        2: load_cell(mask, PMIN, PMAX);
        3: load_cell(4'h0, pick_origin(), pick_origin());
        default: load_cell(mask, pick_origin(), pick_origin());
      endcase
      repeat (PHASE_POSES) begin
        if ($urandom_range(0, 99) < 80) begin
          px = near(cell_ox);
          py = near(cell_oy);
        end else begin
          px = PosW'($urandom);
          py = PosW'($urandom);
        end
        // some headings sit right at an axis, across the dead band
        if ($urandom_range(0, 9) == 0)
          hd = HeadingW'($urandom_range(0, 3) * 16384 + $urandom_range(0, 8) - 4);
        else
          hd = HeadingW'($urandom);
        idle_sender();
        send_pose(px, py, hd, 1'b0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
